// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while the synchronous active-low reset is asserted
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check that also holds during reset
`define ASSERT_CLK_NR(name, clk, prop) \
    name: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- hdl/gcdb_pkg.sv -----
package gcdb_pkg;

    // cordic iteration count, capped at one table length
    localparam int CORDIC_STEPS = 24;
    localparam int STEPS        = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // number of result bits of the square root (radicand below 2^61)
    localparam int SQRT_BITS = 31;

    typedef logic signed [31:0] t_sc;   // sine / cosine, q2.30
    typedef logic signed [33:0] t_rxy;  // rotation cordic x / y
    typedef logic signed [33:0] t_ang;  // binary angle with headroom
    typedef logic signed [33:0] t_q;    // q4.30 product
    typedef logic signed [34:0] t_vin;  // vectoring cordic operand
    typedef logic signed [35:0] t_vx;   // vectoring cordic x / y

    localparam logic [30:0] DEG7_TO_BAM  = 31'd1281023894;
    localparam t_rxy        CORDIC_GAIN  = 34'sd652032874;
    localparam t_ang        QUARTER_TURN = 34'sd1073741824;
    localparam t_ang        HALF_TURN    = 34'sd2147483648;
    localparam t_vin        ONE_Q30      = 35'sd1073741824;
    localparam logic [31:0] CIRC_CM      = 32'd4000783471;
    localparam logic [31:0] TURN_DEG7    = 32'd3600000000;

    // atan(2^-i) in binary-angle units
    localparam logic [31:0] ATAN_BAM [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // unit latencies
    localparam int LAT_ROT = STEPS + 2;
    localparam int LAT_SQ  = SQRT_BITS;
    localparam int LAT_VEC = STEPS + 1;

    // pipeline stage numbers, counted in register levels from the input transfer
    localparam int K_ROT_IN = 5;
    localparam int K_ROT    = K_ROT_IN + LAT_ROT;
    localparam int K_P4     = K_ROT + 4;
    localparam int K_SQ_IN  = K_P4 + 2;
    localparam int K_SQ     = K_SQ_IN + LAT_SQ;
    localparam int K_VEC    = K_SQ + LAT_VEC;
    localparam int K_END    = K_VEC + 4;

endpackage

// ----- hdl/gcdb_cordic_rot.sv -----
module gcdb_cordic_rot import gcdb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_angle,
    output t_sc         o_sin,
    output t_sc         o_cos
);

    t_rxy         r_x [STEPS+1];
    t_rxy         r_y [STEPS+1];
    t_ang         r_z [STEPS+1];
    logic [STEPS:0] r_flip;
    t_sc          r_sin;
    t_sc          r_cos;

    t_ang n_z0;
    t_ang n_zs;
    logic n_flip;

    // fold into [-quarter, quarter] turn, negate the result afterwards
    always_comb begin
        n_z0   = t_ang'($signed(i_angle));
        n_zs   = n_z0;
        n_flip = 1'b0;
        if (n_z0 > QUARTER_TURN) begin
            n_zs   = n_z0 - HALF_TURN;
            n_flip = 1'b1;
        end else if (n_z0 < -QUARTER_TURN) begin
            n_zs   = n_z0 + HALF_TURN;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= n_zs;
            r_flip[0] <= n_flip;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        t_rxy dx;
        t_rxy dy;
        t_ang da;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign da = t_ang'({2'b00, ATAN_BAM[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - da;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + da;
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_flip[STEPS] ? t_sc'(-r_y[STEPS]) : t_sc'(r_y[STEPS]);
            r_cos <= r_flip[STEPS] ? t_sc'(-r_x[STEPS]) : t_sc'(r_x[STEPS]);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ----- hdl/gcdb_isqrt.sv -----
module gcdb_isqrt import gcdb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_rad,
    output logic [30:0] o_root
);

    logic [61:0] r_v [SQRT_BITS];
    logic [61:0] r_r [SQRT_BITS];

    // one result bit per stage, restoring form
    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_bit
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
        logic [61:0] v_in;
        logic [61:0] r_in;
        logic [61:0] trial;
        if (j == 0) begin : g_first
            assign v_in = {1'b0, i_rad};
            assign r_in = '0;
        end else begin : g_next
            assign v_in = r_v[j-1];
            assign r_in = r_r[j-1];
        end
        assign trial = r_in + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (v_in >= trial) begin
                    r_v[j] <= v_in - trial;
                    r_r[j] <= (r_in >> 1) + BIT;
                end else begin
                    r_v[j] <= v_in;
                    r_r[j] <= r_in >> 1;
                end
            end
        end
    end

    assign o_root = r_r[SQRT_BITS-1][30:0];

endmodule

// ----- hdl/gcdb_cordic_vec.sv -----
module gcdb_cordic_vec import gcdb_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_vin i_x,
    input  t_vin i_y,
    output t_ang o_z
);

    t_vx  r_x [STEPS+1];
    t_vx  r_y [STEPS+1];
    t_ang r_z [STEPS+1];

    t_vx  xi;
    t_vx  yi;
    t_vx  n_x;
    t_vx  n_y;
    t_ang n_z;

    // left half plane: pre-rotate by a quarter turn
    always_comb begin
        xi  = t_vx'(i_x);
        yi  = t_vx'(i_y);
        n_x = xi;
        n_y = yi;
        n_z = '0;
        if (xi < 0) begin
            if (yi >= 0) begin
                n_x = yi;
                n_y = -xi;
                n_z = QUARTER_TURN;
            end else begin
                n_x = -yi;
                n_y = xi;
                n_z = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x;
            r_y[0] <= n_y;
            r_z[0] <= n_z;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        t_vx  dx;
        t_vx  dy;
        t_ang da;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign da = t_ang'({2'b00, ATAN_BAM[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] < 0) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - da;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + da;
                end
            end
        end
    end

    assign o_z = r_z[STEPS];

endmodule

// ----- hdl/great_circle_distance_bearing_core.sv -----
// throughput: one position pair per cycle if not stalled; every unit is unrolled, one cordic
//   or root step per stage, so the whole pipeline advances together on a single enable
// a two-entry output (register plus skid) keeps input transfers going while one result waits
// reset: synchronous, active low; clears valid bits and output state, data regs keep contents
module great_circle_distance_bearing_core import gcdb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // start_latitude[30:0], start_longitude[62:31], end_latitude[93:63],
    // end_longitude[125:94], zero pad[127:126]
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // distance_cm[30:0], bearing_angle[62:31], zero pad[63]
    output logic [63:0]  o_m_axis_tdata
);

    // pipeline enable: the whole chain stalls only when the skid entry is full
    logic en;
    logic accept;
    logic r_skid_valid;

    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;

    // ------------------------------------------------------------------
    // stage 1..5: degree units to 32-bit binary angles
    // ------------------------------------------------------------------
    logic signed [31:0] s_field [4];
    logic [31:0]        r_mag   [4];
    logic [62:0]        r_prod  [4];
    logic [31:0]        r_bamu  [4];
    logic [31:0]        r_bam   [4];
    logic [3:0]         r_neg1;
    logic [3:0]         r_neg2;
    logic [3:0]         r_neg3;
    logic [62:0]        n_rnd   [4];
    logic [31:0]        r_lat_a;
    logic [31:0]        r_lat_b;
    logic [31:0]        r_dlon;
    logic               n_coin;

    assign s_field[0] = $signed({i_s_axis_tdata[30], i_s_axis_tdata[30:0]});
    assign s_field[1] = $signed(i_s_axis_tdata[62:31]);
    assign s_field[2] = $signed({i_s_axis_tdata[93], i_s_axis_tdata[93:63]});
    assign s_field[3] = $signed(i_s_axis_tdata[125:94]);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_rnd[k] = r_prod[k] + (63'd1 << 29);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                // magnitude, rounded scale, then sign back on
                r_mag[k]  <= s_field[k][31] ? 32'(32'd0 - s_field[k]) : s_field[k];
                r_neg1[k] <= s_field[k][31];
                r_prod[k] <= 63'(r_mag[k]) * 63'(DEG7_TO_BAM);
                r_neg2[k] <= r_neg1[k];
                r_bamu[k] <= n_rnd[k][61:30];
                r_neg3[k] <= r_neg2[k];
                r_bam[k]  <= r_neg3[k] ? 32'd0 - r_bamu[k] : r_bamu[k];
            end
            r_lat_a <= r_bam[0];
            r_lat_b <= r_bam[2];
            r_dlon  <= r_bam[3] - r_bam[1];
        end
    end

    // coincident points: same latitude angle and longitudes equal modulo a turn
    assign n_coin = (r_bam[0] == r_bam[2]) && (r_bam[1] == r_bam[3]);

    // ------------------------------------------------------------------
    // sine and cosine of both latitudes and of the longitude difference
    // ------------------------------------------------------------------
    t_sc w_sa, w_ca, w_sb, w_cb, w_sd, w_cd;

    gcdb_cordic_rot u_rot_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_angle(r_lat_a),
        .o_sin  (w_sa),
        .o_cos  (w_ca)
    );

    gcdb_cordic_rot u_rot_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_angle(r_lat_b),
        .o_sin  (w_sb),
        .o_cos  (w_cb)
    );

    gcdb_cordic_rot u_rot_d (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_angle(r_dlon),
        .o_sin  (w_sd),
        .o_cos  (w_cd)
    );

    // ------------------------------------------------------------------
    // p1..p4: law-of-cosines term and bearing vector, q2.30
    // ------------------------------------------------------------------
    logic signed [63:0] m_sasb, m_cacb, m_sdcb, m_casb, m_sacb;
    logic signed [65:0] m_t1, m_t2;
    logic signed [63:0] m_csq;
    t_q   r_sasb, r_cacb, r_sdcb, r_casb, r_sacb;
    t_sc  r_cd1;
    t_q   r_t1, r_t2, r_sasb2, r_by2, r_casb2;
    t_vin r_c, r_bx;
    t_q   r_by3;
    t_sc  r_cc;
    t_vin r_bx4;
    t_q   r_by4;
    logic [60:0] r_csq;
    logic [60:0] r_rad;
    t_sc  n_cc;
    logic n_zero;

    assign m_sasb = w_sa * w_sb;
    assign m_cacb = w_ca * w_cb;
    assign m_sdcb = w_sd * w_cb;
    assign m_casb = w_ca * w_sb;
    assign m_sacb = w_sa * w_cb;
    assign m_t1   = r_cacb * r_cd1;
    assign m_t2   = r_sacb * r_cd1;
    assign m_csq  = r_cc * r_cc;

    // saturate the cosine term to [-1, 1]
    always_comb begin
        if (r_c > ONE_Q30) begin
            n_cc = t_sc'(ONE_Q30);
        end else if (r_c < -ONE_Q30) begin
            n_cc = t_sc'(-ONE_Q30);
        end else begin
            n_cc = t_sc'(r_c);
        end
    end

    assign n_zero = (r_bx == '0) && (r_by3 == '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            // p1
            r_sasb  <= t_q'(m_sasb >>> 30);
            r_cacb  <= t_q'(m_cacb >>> 30);
            r_sdcb  <= t_q'(m_sdcb >>> 30);
            r_casb  <= t_q'(m_casb >>> 30);
            r_sacb  <= t_q'(m_sacb >>> 30);
            r_cd1   <= w_cd;
            // p2
            r_t1    <= t_q'(m_t1 >>> 30);
            r_t2    <= t_q'(m_t2 >>> 30);
            r_sasb2 <= r_sasb;
            r_by2   <= r_sdcb;
            r_casb2 <= r_casb;
            // p3
            r_c     <= t_vin'(r_sasb2) + t_vin'(r_t1);
            r_bx    <= t_vin'(r_casb2) - t_vin'(r_t2);
            r_by3   <= r_by2;
            // p4
            r_cc    <= n_cc;
            r_bx4   <= r_bx;
            r_by4   <= r_by3;
            // radicand 1 - c^2 in q1.60
            r_csq   <= m_csq[60:0];
            r_rad   <= (61'd1 << 60) - r_csq;
        end
    end

    // ------------------------------------------------------------------
    // sine of the central angle
    // ------------------------------------------------------------------
    logic [30:0] w_root;

    gcdb_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rad (r_rad),
        .o_root(w_root)
    );

    // cosine term and bearing vector wait for the root
    t_sc  r_c_d  [K_P4+1:K_SQ];
    t_vin r_bx_d [K_P4+1:K_SQ];
    t_q   r_by_d [K_P4+1:K_SQ];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_d[K_P4+1]  <= r_cc;
            r_bx_d[K_P4+1] <= r_bx4;
            r_by_d[K_P4+1] <= r_by4;
            for (int k = K_P4 + 2; k <= K_SQ; k++) begin
                r_c_d[k]  <= r_c_d[k-1];
                r_bx_d[k] <= r_bx_d[k-1];
                r_by_d[k] <= r_by_d[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // arccosine as atan2(root, c) and bearing atan2, side by side
    // ------------------------------------------------------------------
    t_ang w_zd;
    t_ang w_zb;

    gcdb_cordic_vec u_vec_dist (
        .i_clk(i_clk),
        .i_en (en),
        .i_x  (t_vin'(r_c_d[K_SQ])),
        .i_y  (t_vin'({4'b0000, w_root})),
        .o_z  (w_zd)
    );

    gcdb_cordic_vec u_vec_bear (
        .i_clk(i_clk),
        .i_en (en),
        .i_x  (r_bx_d[K_SQ]),
        .i_y  (t_vin'(r_by_d[K_SQ])),
        .o_z  (w_zb)
    );

    // ------------------------------------------------------------------
    // f1..f4: clamp, scale to centimeters and 1e-7 degree, special cases
    // ------------------------------------------------------------------
    logic [K_END:1]         r_vld;
    logic [K_END-1:K_ROT_IN] r_coin;
    logic [K_VEC:K_P4]      r_zero;

    logic [31:0] n_dang;
    t_ang        n_bang;
    logic [31:0] r_dang;
    logic [31:0] r_bmag;
    logic        r_bneg1, r_bneg2, r_bneg3;
    logic [63:0] r_dprod;
    logic [63:0] r_bprod;
    logic [64:0] n_dsum;
    logic [64:0] n_bsum;
    logic [30:0] r_dist;
    logic [31:0] r_bq;
    logic [30:0] r_fdist;
    logic [31:0] r_fbear;

    always_comb begin
        // central angle clamped to [0, half turn]
        if (w_zd < 0) begin
            n_dang = '0;
        end else if (w_zd > HALF_TURN) begin
            n_dang = HALF_TURN[31:0];
        end else begin
            n_dang = w_zd[31:0];
        end
        // bearing clamped to +-half turn, zero vector gives zero
        if (r_zero[K_VEC]) begin
            n_bang = '0;
        end else if (w_zb > HALF_TURN) begin
            n_bang = HALF_TURN;
        end else if (w_zb < -HALF_TURN) begin
            n_bang = -HALF_TURN;
        end else begin
            n_bang = w_zb;
        end
    end

    assign n_dsum = {1'b0, r_dprod} + (65'd1 << 31);
    assign n_bsum = {1'b0, r_bprod} + (65'd1 << 31);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dang  <= n_dang;
            r_bneg1 <= n_bang < 0;
            r_bmag  <= (n_bang < 0) ? 32'(-n_bang) : 32'(n_bang);
            r_dprod <= 64'(r_dang) * 64'(CIRC_CM);
            r_bprod <= 64'(r_bmag) * 64'(TURN_DEG7);
            r_bneg2 <= r_bneg1;
            r_dist  <= n_dsum[62:32];
            r_bq    <= n_bsum[63:32];
            r_bneg3 <= r_bneg2;
            r_fdist <= r_coin[K_END-1] ? '0 : r_dist;
            r_fbear <= r_coin[K_END-1] ? '0 : (r_bneg3 ? 32'd0 - r_bq : r_bq);
        end
    end

    // flags riding along with the data
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_coin <= {r_coin[K_END-2:K_ROT_IN], n_coin};
            r_zero <= {r_zero[K_VEC-1:K_P4], n_zero};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[K_END-1:1], accept};
        end
    end

    // ------------------------------------------------------------------
    // output register with one skid entry
    // ------------------------------------------------------------------
    logic        r_out_valid;
    logic [62:0] r_out_data;
    logic [62:0] r_skid_data;
    logic        out_free;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= en && r_vld[K_END];
            end
        end else if (en && r_vld[K_END]) begin
            // result arrives while the output register is stalled
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : {r_fbear, r_fdist};
        end else if (en) begin
            r_skid_data <= {r_fbear, r_fdist};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_data};

endmodule

// ----- hdl/gcdb_checker.sv -----
`include "assert_macros.svh"

module gcdb_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [127:0] i_s_axis_tdata,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [63:0]  o_m_axis_tdata
);

    // a stalled result stays offered and unchanged
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))

    // distance never exceeds half the circumference
    `ASSERT_CLK(a_dist_range, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[30:0] <= 31'd2000391736))

    // bearing within +-180 degrees
    `ASSERT_CLK(a_bear_range, i_clk, i_rst_n, o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[62:31]) <= 32'sd1800000000 && $signed(o_m_axis_tdata[62:31]) >= -32'sd1800000000))

    // reset empties the output
    `ASSERT_CLK_NR(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind great_circle_distance_bearing_core gcdb_checker u_gcdb_checker (.*);
